// ----- design/bcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the baryon color contraction unit
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int CW = 16;
    localparam int AW = 64;

    typedef logic signed [CW-1:0] comp_t;

    // one accepted word after the front end
    typedef struct packed {
        logic [1:0] color;
        logic [1:0] phase;
        logic       last;
        comp_t      q1_re;
        comp_t      q1_im;
        comp_t      q2_re;
        comp_t      q2_im;
        comp_t      q3_re;
        comp_t      q3_im;
    } item_t;

    localparam logic [1:0] PH_POS_ONE = 2'd0;
    localparam logic [1:0] PH_POS_I   = 2'd1;
    localparam logic [1:0] PH_NEG_ONE = 2'd2;
    localparam logic [1:0] PH_NEG_I   = 2'd3;

    localparam logic [1:0] COLOR_0 = 2'd0;
    localparam logic [1:0] COLOR_1 = 2'd1;
    localparam logic [1:0] COLOR_2 = 2'd2;

    localparam logic [0:0] REG_GAMMA = 1'b0;

endpackage

// ----- design/bcc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_queue
// two-entry queue between front end and contraction engine
// ----------------------------------------------------------------------------
module bcc_queue
    import bcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count");
    a_empty_nopop: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !pop) else $error("queue underflow");
`endif

endmodule

// ----- design/bcc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_engine
// determinant sequencer, phase weighting and saturating accumulator
// ----------------------------------------------------------------------------
module bcc_engine
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  item_t                in_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic signed [AW-1:0] res_re,
    output logic signed [AW-1:0] res_im,
    output logic                 res_sat
);

    typedef enum logic [2:0] {S_IDLE, S_PAIR, S_TRIP, S_ACC, S_EMIT} state_t;

    // color store: entry per color 0 and 1, six components; color 2 is held in c2_reg
    comp_t st_reg [2][6];
    comp_t c2_reg [6];
    logic [1:0] ph_reg;
    logic       last_reg;
    logic [2:0] perm_reg;
    state_t     state_reg;

    logic signed [2*CW:0]   pr_reg, pi_reg;
    logic signed [AW-1:0]   sr_reg, si_reg;
    logic signed [AW-1:0]   acc_re_reg, acc_im_reg;
    logic                   clip_reg;
    logic signed [AW-1:0]   out_re_reg, out_im_reg;
    logic                   out_sat_reg, out_v_reg;

    comp_t ar, ai, br, bi, cr, ci;
    logic [1:0] ia, ib, ic;
    comp_t col_a [3][2];
    comp_t col_b [3][2];
    comp_t col_c [3][2];

    // permutation table: (a,b,c), first three even
    always_comb
    begin
        unique case (perm_reg)
            3'd0: begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
            3'd1: begin ia = 2'd1; ib = 2'd2; ic = 2'd0; end
            3'd2: begin ia = 2'd2; ib = 2'd0; ic = 2'd1; end
            3'd3: begin ia = 2'd2; ib = 2'd1; ic = 2'd0; end
            3'd4: begin ia = 2'd1; ib = 2'd0; ic = 2'd2; end
            default: begin ia = 2'd0; ib = 2'd2; ic = 2'd1; end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            col_a[k][0] = st_reg[k][0]; col_a[k][1] = st_reg[k][1];
            col_b[k][0] = st_reg[k][2]; col_b[k][1] = st_reg[k][3];
            col_c[k][0] = st_reg[k][4]; col_c[k][1] = st_reg[k][5];
        end
        col_a[2][0] = c2_reg[0]; col_a[2][1] = c2_reg[1];
        col_b[2][0] = c2_reg[2]; col_b[2][1] = c2_reg[3];
        col_c[2][0] = c2_reg[4]; col_c[2][1] = c2_reg[5];
        ar = col_a[ia][0]; ai = col_a[ia][1];
        br = col_b[ib][0]; bi = col_b[ib][1];
        cr = col_c[ic][0]; ci = col_c[ic][1];
    end

    // stage products
    logic signed [2*CW:0]  pr_next, pi_next;
    logic signed [AW-1:0]  tr, ti, sr_next, si_next;
    logic signed [3*CW:0]  prc, pic, pri, pir;
    logic                  perm_c_reg;
    comp_t                 cr_reg, ci_reg;

    assign pr_next = (2*CW+1)'(ar * br) - (2*CW+1)'(ai * bi);
    assign pi_next = (2*CW+1)'(ar * bi) + (2*CW+1)'(ai * br);
    // pair product times one component, exact at 3*CW+1 bits
    assign prc = pr_reg * cr_reg;
    assign pic = pi_reg * ci_reg;
    assign pri = pr_reg * ci_reg;
    assign pir = pi_reg * cr_reg;
    assign tr  = AW'(prc) - AW'(pic);
    assign ti  = AW'(pri) + AW'(pir);
    assign sr_next = perm_c_reg ? sr_reg - tr : sr_reg + tr;
    assign si_next = perm_c_reg ? si_reg - ti : si_reg + ti;

    // phase weighting and saturation
    logic signed [AW-1:0] wr, wi, nr, ni;
    logic                 cr_clip, ci_clip;
    logic signed [AW:0]   er, ei;
    localparam logic signed [AW-1:0] MX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] MN = {1'b1, {(AW-1){1'b0}}};

    always_comb
    begin
        unique case (ph_reg)
            PH_POS_ONE: begin wr = sr_reg;      wi = si_reg;      end
            PH_POS_I:   begin wr = -si_reg;     wi = sr_reg;      end
            PH_NEG_ONE: begin wr = -sr_reg;     wi = -si_reg;     end
            default:    begin wr = si_reg;      wi = -sr_reg;     end
        endcase
        er = {acc_re_reg[AW-1], acc_re_reg} + {wr[AW-1], wr};
        ei = {acc_im_reg[AW-1], acc_im_reg} + {wi[AW-1], wi};
        cr_clip = er[AW] != er[AW-1];
        ci_clip = ei[AW] != ei[AW-1];
        nr = cr_clip ? (er[AW] ? MN : MX) : er[AW-1:0];
        ni = ci_clip ? (ei[AW] ? MN : MX) : ei[AW-1:0];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = out_v_reg;
    assign res_re    = out_re_reg;
    assign res_im    = out_im_reg;
    assign res_sat   = out_sat_reg;

    logic take;
    assign take = in_valid && in_ready;

    // sequencer: pair product (reg) then triple product into the sum, per permutation
    logic pipe_reg;

    always_ff @(posedge clk)
    begin
        if (take && (in_item.color == COLOR_0 || in_item.color == COLOR_1))
        begin
            st_reg[in_item.color[0]][0] <= in_item.q1_re;
            st_reg[in_item.color[0]][1] <= in_item.q1_im;
            st_reg[in_item.color[0]][2] <= in_item.q2_re;
            st_reg[in_item.color[0]][3] <= in_item.q2_im;
            st_reg[in_item.color[0]][4] <= in_item.q3_re;
            st_reg[in_item.color[0]][5] <= in_item.q3_im;
        end
        if (take)
        begin
            c2_reg[0] <= in_item.q1_re; c2_reg[1] <= in_item.q1_im;
            c2_reg[2] <= in_item.q2_re; c2_reg[3] <= in_item.q2_im;
            c2_reg[4] <= in_item.q3_re; c2_reg[5] <= in_item.q3_im;
            ph_reg    <= in_item.phase;
        end
        pr_reg     <= pr_next;
        pi_reg     <= pi_next;
        cr_reg     <= cr;
        ci_reg     <= ci;
        perm_c_reg <= (perm_reg >= 3'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            perm_reg    <= 3'd0;
            pipe_reg    <= 1'b0;
            last_reg    <= 1'b0;
            sr_reg      <= '0;
            si_reg      <= '0;
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            clip_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            out_re_reg  <= '0;
            out_im_reg  <= '0;
            out_sat_reg <= 1'b0;
        end
        else
        begin
            if (out_v_reg && res_ready && state_reg != S_EMIT) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        last_reg <= in_item.last;
                        perm_reg <= 3'd0;
                        pipe_reg <= 1'b0;
                        sr_reg   <= '0;
                        si_reg   <= '0;
                        if (in_item.color == COLOR_2)
                            state_reg <= S_PAIR;
                        else if (in_item.last)
                            state_reg <= S_EMIT;
                    end
                end
                S_PAIR:
                begin
                    // product of perm_reg is registered; sum the previous one
                    if (pipe_reg)
                    begin
                        sr_reg <= sr_next;
                        si_reg <= si_next;
                    end
                    pipe_reg <= 1'b1;
                    if (perm_reg == 3'd5)
                        state_reg <= S_TRIP;
                    else
                        perm_reg <= perm_reg + 3'd1;
                end
                S_TRIP:
                begin
                    sr_reg    <= sr_next;
                    si_reg    <= si_next;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_re_reg <= nr;
                    acc_im_reg <= ni;
                    clip_reg   <= clip_reg | cr_clip | ci_clip;
                    state_reg  <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (!out_v_reg || res_ready)
                    begin
                        out_v_reg   <= 1'b1;
                        out_re_reg  <= acc_re_reg;
                        out_im_reg  <= acc_im_reg;
                        out_sat_reg <= clip_reg;
                        acc_re_reg  <= '0;
                        acc_im_reg  <= '0;
                        clip_reg    <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_v_reg || res_ready)) |=>
        (out_v_reg && acc_re_reg == '0 && !clip_reg)) else $error("emit");
    a_perm_range: assert property (@(posedge clk) disable iff (!rst_n)
        perm_reg <= 3'd5) else $error("perm index");
    a_trip_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRIP |-> $past(state_reg) == S_PAIR) else $error("seq");
`endif

endmodule

// ----- design/bcc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_front
// input acceptance, phase lookup and configuration register
// ----------------------------------------------------------------------------
module bcc_front
    import bcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  color,
    input  logic [1:0]  spin,
    input  comp_t       q1_re, q1_im, q2_re, q2_im, q3_re, q3_im,
    input  logic        last,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    logic [7:0] gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= 8'd0;
        else if (psel && penable && pwrite && paddr == REG_GAMMA)
            gamma_reg <= pwdata[7:0];
    end

    assign prdata = (paddr == REG_GAMMA) ? {24'd0, gamma_reg} : 32'd0;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    always_comb
    begin
        q_item.color = color;
        q_item.phase = gamma_reg[{spin, 1'b0} +: 2];
        q_item.last  = last;
        q_item.q1_re = q1_re; q_item.q1_im = q1_im;
        q_item.q2_re = q2_re; q_item.q2_im = q2_im;
        q_item.q3_re = q3_re; q_item.q3_im = q3_im;
    end

endmodule

// ----- design/baryon_color_contraction_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baryon_color_contraction_unit
// su(3) epsilon contraction of three quark fields with saturating accumulation
// ----------------------------------------------------------------------------
// color 0/1 words are stored and leave the engine ready for the next word unless last;
// a color 2 word keeps it busy (six permutations through one shared complex triple-product path, then accumulate)
// the result word is registered in the emit state after the engine takes a last word of
// color 0, 1 or 3, or after the pair, triple and accumulate states for a last color 2 word
// a two-word registered queue decouples input acceptance from the engine
// reset clears accumulators, clip flag, gamma register and queue; color store is not cleared
module baryon_color_contraction_unit
    import bcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // color[1:0], spin[3:2], q1_re, q1_im, q2_re, q2_im, q3_re, q3_im (16 each), pad
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corr_re[63:0], corr_im[127:64]
    output logic [127:0] m_tdata,
    // saturated
    output logic         m_tuser
);

    logic  fq_valid, fq_ready, qe_valid, qe_ready;
    item_t fq_item, qe_item;
    logic signed [AW-1:0] re, im;

    assign pready = 1'b1;

    bcc_front u_front (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .color(s_tdata[1:0]), .spin(s_tdata[3:2]),
        .q1_re(s_tdata[19:4]), .q1_im(s_tdata[35:20]),
        .q2_re(s_tdata[51:36]), .q2_im(s_tdata[67:52]),
        .q3_re(s_tdata[83:68]), .q3_im(s_tdata[99:84]),
        .last(s_tlast),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    bcc_queue u_queue (
        .clk, .rst_n,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
        .out_valid(qe_valid), .out_ready(qe_ready), .out_item(qe_item)
    );

    bcc_engine u_engine (
        .clk, .rst_n,
        .in_valid(qe_valid), .in_ready(qe_ready), .in_item(qe_item),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_re(re), .res_im(im), .res_sat(m_tuser)
    );

    assign m_tdata = {im, re};

endmodule
